/* src/bhtr_pkg.sv */
// ----------------------------------------------------------------------------
// bhtr_pkg
// Shared types, constants and helpers for the bucketed hash table with
// age/depth replacement.
// ----------------------------------------------------------------------------
package bhtr_pkg;

  localparam int NumBucketsDef = 1024;
  localparam int WaysDef       = 4;

  localparam int KeyW   = 64;
  localparam int TagW   = 32;
  localparam int MoveW  = 32;
  localparam int ScoreW = 16;
  localparam int DepthW = 8;
  localparam int KindW  = 2;
  localparam int AgeW   = 16;
  localparam int EvalW  = 16;
  localparam int CountW = 13;
  localparam int OutWayW = 2;

  localparam int AgeShift = 9;
  localparam int RankW    = AgeW + AgeShift;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [KindW-1:0] KIND_EMPTY = '0;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic [MoveW-1:0]         move;
    logic signed [ScoreW-1:0] score;
    logic [DepthW-1:0]        depth;
    logic [KindW-1:0]         kind;
    logic [AgeW-1:0]          age;
    logic signed [EvalW-1:0]  eval;
  } entry_t;

  // address width for a store of n rows, never below one bit
  function automatic int addr_w(int n);
    int r;
    r = $clog2(n);
    return (r < 1) ? 1 : r;
  endfunction

endpackage

/* src/bhtr_ram.sv */
// ----------------------------------------------------------------------------
// bhtr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (holds while not read).
// ----------------------------------------------------------------------------
module bhtr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = bhtr_pkg::addr_w(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bhtr_bucket.sv */
// ----------------------------------------------------------------------------
// bhtr_bucket
// Bucket index from the position key: key modulo the bucket count. For a
// power-of-two count this is a mask and done follows start in the same
// cycle; otherwise a residue unit takes four key bits per cycle.
// ----------------------------------------------------------------------------
module bhtr_bucket #(
  parameter int NumBuckets = bhtr_pkg::NumBucketsDef,
  parameter int BktW       = bhtr_pkg::addr_w(NumBuckets)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bhtr_pkg::KeyW-1:0] key_i,
  output logic                      done_o,
  output logic [BktW-1:0]           idx_o
);

  localparam bit IsPow2 = ((NumBuckets & (NumBuckets - 1)) == 0);

  if (IsPow2) begin : g_mask
    localparam logic [BktW-1:0] Mask = BktW'(NumBuckets - 1);

    assign done_o = start_i;
    assign idx_o  = key_i[BktW-1:0] & Mask;

  end else begin : g_residue
    localparam int DigW  = 4;
    localparam int Steps = bhtr_pkg::KeyW / DigW;
    localparam int CntW  = $clog2(Steps);
    localparam logic [BktW:0]     Modulus = (BktW + 1)'(NumBuckets);
    localparam logic [CntW-1:0]   LastCnt = CntW'(Steps - 1);

    logic                      busy_q, done_q;
    logic [CntW-1:0]           cnt_q;
    logic [bhtr_pkg::KeyW-1:0] key_q;
    logic [BktW-1:0]           rem_q, rem_d;

    // rem = (rem * 2 + bit) mod N, four bits MSB first
    always_comb begin
      logic [BktW:0] t;
      rem_d = rem_q;
      for (int i = 0; i < DigW; i++) begin
        t = {rem_d, key_q[bhtr_pkg::KeyW-1-i]};
        if (t >= Modulus) begin
          t = t - Modulus;
        end
        rem_d = t[BktW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastCnt) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
        rem_q <= '0;
      end else if (busy_q) begin
        key_q <= key_q << DigW;
        rem_q <= rem_d;
      end
    end

    assign done_o = done_q;
    assign idx_o  = rem_q;
  end

endmodule

/* src/bucketed_hash_table_with_replacement_unit.sv */
// ----------------------------------------------------------------------------
// bucketed_hash_table_with_replacement_unit
// Set-associative position table with age/depth replacement.
// ----------------------------------------------------------------------------
// Channels: an input request (cmd, key, entry data) and a result channel,
// both valid/ready. Every request gives exactly one result. A lookup returns
// the first occupied way with a matching tag; an insert writes the chosen
// way stamped with the current search age and reports the entry as written.
// The search age is written through the cfg channel, always ready.
// Each bucket is one row of a single synchronous RAM. With a power-of-two
// bucket count the cycle that takes a request also reads the bucket row;
// other bucket counts first run the key residue unit. The compare stage
// checks all ways and, once the result slot is free, writes the row back on
// insert and loads the result register. No new request is taken until the
// last one has left the compare stage. A stalled result register holds its
// result; a new request may be taken meanwhile, and its compare waits until
// the result slot frees up. After reset the RAM is cleared one bucket per
// cycle, all buckets, no request taken; cfg writes are taken throughout.
// ----------------------------------------------------------------------------
module bucketed_hash_table_with_replacement_unit #(
  parameter int NUM_BUCKETS = bhtr_pkg::NumBucketsDef,
  parameter int WAYS        = bhtr_pkg::WaysDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bhtr_pkg::AgeW-1:0]         cfg_search_age_i,
  // requests
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [bhtr_pkg::KeyW-1:0]         position_key_i,
  input  logic [bhtr_pkg::DepthW-1:0]       search_depth_i,
  input  logic signed [bhtr_pkg::ScoreW-1:0] search_score_i,
  input  logic [bhtr_pkg::KindW-1:0]        bound_kind_i,
  input  logic [bhtr_pkg::MoveW-1:0]        best_move_i,
  input  logic signed [bhtr_pkg::EvalW-1:0] static_eval_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [bhtr_pkg::OutWayW-1:0]      way_index_o,
  output logic [bhtr_pkg::MoveW-1:0]        entry_move_o,
  output logic signed [bhtr_pkg::ScoreW-1:0] entry_score_o,
  output logic [bhtr_pkg::DepthW-1:0]       entry_depth_o,
  output logic [bhtr_pkg::KindW-1:0]        entry_kind_o,
  output logic [bhtr_pkg::AgeW-1:0]         entry_age_o,
  output logic signed [bhtr_pkg::EvalW-1:0] entry_eval_o,
  output logic [bhtr_pkg::CountW-1:0]       occupied_count_o
);

  localparam int BktW   = bhtr_pkg::addr_w(NUM_BUCKETS);
  localparam int WayW   = bhtr_pkg::addr_w(WAYS);
  localparam int EntryW = $bits(bhtr_pkg::entry_t);
  localparam int RowW   = WAYS * EntryW;
  localparam logic [BktW-1:0] LastBkt = BktW'(NUM_BUCKETS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_LOOK  = 2'd3;

  typedef bhtr_pkg::entry_t [WAYS-1:0] row_t;

  logic [1:0]                      st_q, st_d;
  logic [BktW-1:0]                 clr_q;
  logic [bhtr_pkg::AgeW-1:0]       age_q;
  logic [bhtr_pkg::CountW-1:0]     count_q, count_d;
  logic                            out_valid_q;

  // latched request
  logic                            cmd_q;
  logic [bhtr_pkg::TagW-1:0]       tag_q;
  logic [bhtr_pkg::MoveW-1:0]      move_q;
  logic signed [bhtr_pkg::ScoreW-1:0] score_q;
  logic [bhtr_pkg::DepthW-1:0]     depth_q;
  logic [bhtr_pkg::KindW-1:0]      kind_q;
  logic signed [bhtr_pkg::EvalW-1:0] eval_q;
  logic [BktW-1:0]                 bkt_q;

  // result register payload
  logic                            hit_q;
  logic [bhtr_pkg::OutWayW-1:0]    way_q;
  bhtr_pkg::entry_t                res_q, res_d;
  logic [bhtr_pkg::CountW-1:0]     occ_q;

  logic                            in_fire, go;
  logic                            hash_done;
  logic [BktW-1:0]                 hash_idx;
  logic                            ram_we;
  logic [BktW-1:0]                 ram_waddr;
  logic [RowW-1:0]                 ram_rdata;
  row_t                            rd_row, wr_row;

  logic                            hit_d;
  logic [WayW-1:0]                 look_way, ins_way, sel_way;
  logic                            look_found;
  bhtr_pkg::entry_t                old_e, new_e;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign go          = (st_q == ST_LOOK) & (~out_valid_q | out_ready_i);

  bhtr_bucket #(
    .NumBuckets(NUM_BUCKETS),
    .BktW      (BktW)
  ) u_bucket (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire),
    .key_i  (position_key_i),
    .done_o (hash_done),
    .idx_o  (hash_idx)
  );

  assign ram_we    = (st_q == ST_CLEAR) | (go & (cmd_q == bhtr_pkg::CMD_INSERT));
  assign ram_waddr = (st_q == ST_CLEAR) ? clr_q : bkt_q;

  bhtr_ram #(
    .Width(RowW),
    .Depth(NUM_BUCKETS),
    .AddrW(BktW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i((st_q == ST_CLEAR) ? '0 : wr_row),
    .re_i   (hash_done),
    .raddr_i(hash_idx),
    .rdata_o(ram_rdata)
  );

  assign rd_row = row_t'(ram_rdata);

  // way compare and replacement choice over the bucket row
  always_comb begin
    logic                      fit_found;
    logic [WayW-1:0]           fit_way, min_way;
    logic [bhtr_pkg::RankW-1:0] rank, min_rank;
    logic                      tag_eq, occ;

    look_found = 1'b0;
    look_way   = '0;
    fit_found  = 1'b0;
    fit_way    = '0;
    min_way    = '0;
    min_rank   = (bhtr_pkg::RankW'(rd_row[0].age) << bhtr_pkg::AgeShift)
               + bhtr_pkg::RankW'(rd_row[0].depth);
    for (int w = 0; w < WAYS; w++) begin
      tag_eq = (rd_row[w].tag == tag_q);
      occ    = (rd_row[w].kind != bhtr_pkg::KIND_EMPTY);
      rank   = (bhtr_pkg::RankW'(rd_row[w].age) << bhtr_pkg::AgeShift)
             + bhtr_pkg::RankW'(rd_row[w].depth);
      if (!look_found && occ && tag_eq) begin
        look_found = 1'b1;
        look_way   = WayW'(w);
      end
      if (!fit_found && (!occ || tag_eq)) begin
        fit_found = 1'b1;
        fit_way   = WayW'(w);
      end
      if (rank < min_rank) begin
        min_rank = rank;
        min_way  = WayW'(w);
      end
    end
    ins_way = fit_found ? fit_way : min_way;
  end

  always_comb begin
    old_e = rd_row[ins_way];
    new_e.tag   = tag_q;
    // same tag and no new move: the stored move survives
    new_e.move  = ((old_e.tag == tag_q) && (move_q == '0)) ? old_e.move : move_q;
    new_e.score = score_q;
    new_e.depth = depth_q;
    new_e.kind  = kind_q;
    new_e.age   = age_q;
    new_e.eval  = eval_q;

    wr_row          = rd_row;
    wr_row[ins_way] = new_e;

    unique case (cmd_q)
      bhtr_pkg::CMD_INSERT: begin
        hit_d   = 1'b1;
        sel_way = ins_way;
        res_d   = new_e;
      end
      default: begin
        hit_d   = look_found;
        sel_way = look_found ? look_way : '0;
        res_d   = look_found ? rd_row[look_way] : '0;
      end
    endcase

    count_d = count_q;
    if (go && (cmd_q == bhtr_pkg::CMD_INSERT) && (old_e.kind == bhtr_pkg::KIND_EMPTY)
        && (count_q != bhtr_pkg::COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (clr_q == LastBkt) st_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) st_d = hash_done ? ST_LOOK : ST_HASH;
      end
      ST_HASH: if (hash_done) st_d = ST_LOOK;
      ST_LOOK: if (go) st_d = ST_IDLE;
      default: st_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      age_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      if (st_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i) begin
        age_q <= cfg_search_age_i;
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_i;
      tag_q   <= position_key_i[bhtr_pkg::KeyW-1 -: bhtr_pkg::TagW];
      move_q  <= best_move_i;
      score_q <= search_score_i;
      depth_q <= search_depth_i;
      kind_q  <= bound_kind_i;
      eval_q  <= static_eval_i;
    end
    if (hash_done) begin
      bkt_q <= hash_idx;
    end
    if (go) begin
      hit_q <= hit_d;
      way_q <= bhtr_pkg::OutWayW'(sel_way);
      res_q <= res_d;
      occ_q <= count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign way_index_o      = way_q;
  assign entry_move_o     = res_q.move;
  assign entry_score_o    = res_q.score;
  assign entry_depth_o    = res_q.depth;
  assign entry_kind_o     = res_q.kind;
  assign entry_age_o      = res_q.age;
  assign entry_eval_o     = res_q.eval;
  assign occupied_count_o = occ_q;

`ifndef ASSERT_OFF
  // fill count moves by at most one per cycle and never backward
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1))
    else $error("fill count jumped");

  // RAM is written only by the clear sweep or an insert write-back
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (st_q == ST_CLEAR) || ((st_q == ST_LOOK) && (cmd_q == bhtr_pkg::CMD_INSERT)))
    else $error("unexpected RAM write");

  // compare stage is entered only right after the bucket row was read
  a_read_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_LOOK) && ($past(st_q) != ST_LOOK)) |-> $past(hash_done))
    else $error("compare without row read");

  // a new result comes only from the compare stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == ST_LOOK))
    else $error("result without compare");
`endif

endmodule
